/* rtl/core/frame_rate_from_pixel_clock_defines.svh */
// Assertion macros shared by the frame rate block.
`ifndef FRAME_RATE_FROM_PIXEL_CLOCK_DEFINES_SVH
`define FRAME_RATE_FROM_PIXEL_CLOCK_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FRPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FRPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/frpc_pkg.sv */
package frpc_pkg;

    localparam int NUM_W = 42;
    localparam int DEN_W = 32;
    localparam int CLK_W = 32;
    localparam int DIM_W = 16;
    localparam int OUT_W = 32;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int K_W   = $clog2(DEN_W);

    localparam logic [9:0] CLOCK_SCALE = 10'd1000;

    typedef struct packed {
        logic [OUT_W-1:0] den;
        logic [OUT_W-1:0] num;
    } t_frpc_res;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_frpc_stat;

endpackage

/* rtl/core/frame_rate_from_pixel_clock.sv */
// Frame rate from pixel clock: reduces (pixel clock kHz * 1000) / (width * height)
// to a fraction whose terms each fit in 32 bits.
// Input channel s_axis carries one item: pixel clock in kHz, total line width
// and total frame height. Output channel m_axis carries one item per input:
// the numerator in the low word and the denominator in the high word.
// A zero denominator gives 1/0, a zero clock gives 0/1, and both zero give 0/0.
// The zero cases skip straight to normalizing. Otherwise the binary GCD loop does
// one shift, subtract or swap per cycle on the shared 42-bit subtractor, followed
// by two restoring divisions of 42 and 32 quotient bits on the same subtractor
// and up to 10 normalizing shifts. Division is skipped when the divisor is one.
// One item is in work at a time; s_axis_tready is high only while the engine
// is idle. A finished result sits in the output register, so the next item is
// accepted while m_axis waits; if that one finishes before the receiver takes
// the previous result, the engine holds it until the output register frees.
// Synchronous active-low reset empties the output register and idles the engine.
`include "frame_rate_from_pixel_clock_defines.svh"

module frame_rate_from_pixel_clock
    import frpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pixel_clock_khz[31:0], total_line_width[47:32], total_frame_height[63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rate_numerator[31:0], rate_denominator[63:32]
    output logic [63:0] m_axis_tdata
);

    t_frpc_stat eng_stat;
    t_frpc_res  eng_res;
    logic       in_accept;
    logic       out_load;
    logic       r_m_valid;
    t_frpc_res  r_m_data;

    assign s_axis_tready = eng_stat.idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = eng_stat.res_valid && (!r_m_valid || m_axis_tready);

    frpc_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_pclk_khz (s_axis_tdata[31:0]),
        .i_width    (s_axis_tdata[47:32]),
        .i_height   (s_axis_tdata[63:48]),
        .i_ack      (out_load),
        .o_stat     (eng_stat),
        .o_res      (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= eng_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `FRPC_ASSERT_NXT(a_busy_after_accept, in_accept, !s_axis_tready, "engine idle after accept")
    `FRPC_ASSERT_IMP(a_load_needs_room, out_load, !r_m_valid || m_axis_tready, "result overwritten")
    `FRPC_ASSERT_NXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while waiting")
    `FRPC_ASSERT_NXT(a_result_held, eng_stat.res_valid && !out_load, eng_stat.res_valid, "result dropped by engine")

endmodule

/* rtl/core/frpc_alu.sv */
module frpc_alu
    import frpc_pkg::*;
(
    input  logic [NUM_W-1:0] i_a,
    input  logic [NUM_W-1:0] i_b,
    output logic [NUM_W-1:0] o_diff,
    output logic             o_borrow
);

    logic [NUM_W:0] diff_ext;

    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[NUM_W-1:0];
    assign o_borrow = diff_ext[NUM_W];

endmodule

/* rtl/core/frpc_engine.sv */
module frpc_engine
    import frpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CLK_W-1:0] i_pclk_khz,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic             i_ack,
    output t_frpc_stat       o_stat,
    output t_frpc_res        o_res
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_TWOS   = 8'b0000_0100,
        S_REDUCE = 8'b0000_1000,
        S_DIVN   = 8'b0001_0000,
        S_DIVD   = 8'b0010_0000,
        S_NORM   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [DEN_W-1:0]   r_den, n_den;
    logic [NUM_W-1:0]   r_u, n_u;
    logic [NUM_W-1:0]   r_v, n_v;
    logic [K_W-1:0]     r_k, n_k;
    logic [DEN_W-1:0]   r_g, n_g;
    logic [DEN_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic [NUM_W-1:0]   alu_a, alu_b, alu_diff;
    logic               alu_borrow;
    logic [DEN_W:0]     trial_num, trial_den;
    logic [DEN_W-1:0]   g_val;
    logic [NUM_W-1:0]   v_shl;

    frpc_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_diff   (alu_diff),
        .o_borrow (alu_borrow)
    );

    assign trial_num = {r_rem, r_num[NUM_W-1]};
    assign trial_den = {r_rem, r_den[DEN_W-1]};
    assign v_shl     = r_v << r_k;
    assign g_val     = v_shl[DEN_W-1:0];

    always_comb begin
        case (r_state)
            S_DIVN: begin
                alu_a = NUM_W'(trial_num);
                alu_b = NUM_W'(r_g);
            end
            S_DIVD: begin
                alu_a = NUM_W'(trial_den);
                alu_b = NUM_W'(r_g);
            end
            default: begin
                alu_a = r_u;
                alu_b = r_v;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_den   = r_den;
        n_u     = r_u;
        n_v     = r_v;
        n_k     = r_k;
        n_g     = r_g;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_num   = NUM_W'(i_pclk_khz) * NUM_W'(CLOCK_SCALE);
                    n_den   = DEN_W'(i_width) * DEN_W'(i_height);
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_num == '0) begin
                    n_den   = (r_den == '0) ? '0 : DEN_W'(1);
                    n_state = S_NORM;
                end else if (r_den == '0) begin
                    n_num   = NUM_W'(1);
                    n_state = S_NORM;
                end else begin
                    n_u     = r_num;
                    n_v     = NUM_W'(r_den);
                    n_k     = '0;
                    n_state = S_TWOS;
                end
            end
            S_TWOS: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + K_W'(1);
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (r_u == '0) begin
                    n_g = g_val;
                    if (g_val == DEN_W'(1)) begin
                        n_state = S_NORM;
                    end else begin
                        n_rem   = '0;
                        n_cnt   = CNT_W'(NUM_W - 1);
                        n_state = S_DIVN;
                    end
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (!alu_borrow) begin
                    n_u = {1'b0, alu_diff[NUM_W-1:1]};
                end else begin
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            S_DIVN: begin
                n_rem = alu_borrow ? trial_num[DEN_W-1:0] : alu_diff[DEN_W-1:0];
                n_num = {r_num[NUM_W-2:0], !alu_borrow};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_rem   = '0;
                    n_cnt   = CNT_W'(DEN_W - 1);
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                n_rem = alu_borrow ? trial_den[DEN_W-1:0] : alu_diff[DEN_W-1:0];
                n_den = {r_den[DEN_W-2:0], !alu_borrow};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_num[NUM_W-1:OUT_W] != '0) begin
                    n_num = r_num >> 1;
                    n_den = r_den >> 1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_den <= n_den;
        r_u   <= n_u;
        r_v   <= n_v;
        r_k   <= n_k;
        r_g   <= n_g;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_stat.idle      = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_res.num        = r_num[OUT_W-1:0];
    assign o_res.den        = r_den;

endmodule

/* verif/testbench.sv */
module testbench;
    import frpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // pixel_clock_khz[31:0], total_line_width[47:32], total_frame_height[63:48]
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // rate_numerator[31:0], rate_denominator[63:32]
    logic [63:0] m_axis_tdata;

    t_frpc_res   expected_rates[$];
    t_frpc_res   got_rate;
    t_frpc_res   want_rate;
    int          mismatch_count = 0;
    int          rate_count = 0;
    bit          source_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int          long_hold_cycles = 0;

    frame_rate_from_pixel_clock u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_frpc_res reduce_frame_rate(input logic [31:0] clk_khz,
                                                    input logic [15:0] width,
                                                    input logic [15:0] height);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        t_frpc_res   res;
        num = {32'd0, clk_khz} * {54'd0, CLOCK_SCALE};
        den = {48'd0, width} * {48'd0, height};
        a = num;
        b = den;
        while (b != 64'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        if (a > 64'd1) begin
            num = num / a;
            den = den / a;
        end
        while (num > 64'hFFFF_FFFF || den > 64'hFFFF_FFFF) begin
            num = num >> 1;
            den = den >> 1;
        end
        res.num = num[31:0];
        res.den = den[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch at result %0d: %s, expected %0d, got %0d",
                 rate_count, what, want, got);
        mismatch_count++;
    endtask

    // The valid line stays high between back-to-back items and drops only for a gap.
    task automatic send_format(input logic [31:0] clk_khz, input logic [15:0] width,
                               input logic [15:0] height);
        int gap;
        if (source_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {height, width, clk_khz};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_rates.push_back(reduce_frame_rate(clk_khz, width, height));
    endtask

    task automatic send_random_format();
        logic [31:0] clk_khz;
        logic [15:0] width;
        logic [15:0] height;
        clk_khz = $urandom();
        width   = 16'($urandom());
        height  = 16'($urandom());
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                clk_khz = $urandom_range(10000, 600000);
                width   = 16'($urandom_range(100, 4400));
                height  = 16'($urandom_range(100, 2250));
            end
            5: ;
            6: clk_khz = $urandom_range(4294968, 32'hFFFF_FFFF);
            7: begin
                clk_khz = $urandom_range(0, 255);
                width   = 16'($urandom_range(0, 63));
                height  = 16'($urandom_range(0, 63));
            end
            8: begin
                case ($urandom_range(0, 2))
                    0: clk_khz = 32'd0;
                    1: width = 16'd0;
                    default: height = 16'd0;
                endcase
            end
            default: begin
                width   = 16'($urandom_range(1, 4095));
                height  = 16'($urandom_range(1, 4095));
                clk_khz = {16'd0, width} * $urandom_range(1, 65535);
            end
        endcase
        send_format(clk_khz, width, height);
    endtask

    task automatic test_reduction_corners();
        send_format(32'd0, 16'd0, 16'd0);
        send_format(32'd27000, 16'd0, 16'd1125);
        send_format(32'd0, 16'd2200, 16'd1125);
        send_format(32'd148500, 16'd2200, 16'd1125);
        send_format(32'd148352, 16'd2200, 16'd1125);
        send_format(32'd25175, 16'd800, 16'd525);
        send_format(32'd1, 16'd1, 16'd1);
        send_format(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_format(32'hFFFF_FFFF, 16'd1, 16'd1);
        send_format(32'd4294967, 16'd1, 16'd1);
        send_format(32'd4294968, 16'd1, 16'd1);
        send_format(32'hFFFF_FFFF, 16'd0, 16'd0);
        send_format(32'd0, 16'hFFFF, 16'hFFFF);
        send_format(32'd1, 16'hFFFF, 16'hFFFF);
        send_format(32'hAAAA_AAAA, 16'h5555, 16'hAAAA);
        send_format(32'h5555_5555, 16'hAAAA, 16'h5555);
        send_format(32'd1, 16'hFFFF, 16'd1);
        send_format(32'h8000_0000, 16'h8000, 16'h8000);
    endtask

    task automatic test_random_formats();
        repeat (330) send_random_format();
    endtask

    // The receiver holds off long enough that the engine and the output register fill up.
    task automatic test_output_backpressure();
        long_hold_cycles = 600;
        repeat (16) send_random_format();
    endtask

    task automatic test_back_to_back();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (40) send_random_format();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_cycles > 0) begin
                stall_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_rate = m_axis_tdata;
            if (expected_rates.size() == 0) begin
                report_mismatch("result with nothing pending", 32'd0, got_rate.num);
            end else begin
                want_rate = expected_rates.pop_front();
                if (got_rate.num != want_rate.num) begin
                    report_mismatch("rate_numerator", want_rate.num, got_rate.num);
                end
                if (got_rate.den != want_rate.den) begin
                    report_mismatch("rate_denominator", want_rate.den, got_rate.den);
                end
            end
            rate_count++;
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 64'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reduction_corners();
        test_random_formats();
        test_output_backpressure();
        test_back_to_back();
        s_axis_tvalid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/frpc_pkg.sv
rtl/core/frpc_alu.sv
rtl/core/frpc_engine.sv
rtl/core/frame_rate_from_pixel_clock.sv
verif/testbench.sv
